>>> rtl/lifeb_pkg.sv
// Shared types and helpers for the life board generation step core.
// Holds the request kind codes, configuration register indexes and the B3/S23 cell rule.
// No dependencies.
package lifeb_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_TOGGLE = 2'd2,
		KIND_STEP   = 2'd3
	} kind_t;

	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam logic [6:0] DIM_RESET = 7'd64;

	function automatic logic life_rule(input logic self_alive, input logic [7:0] nb);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'd0, nb[k]};
		end
		return (n == 4'd3) || (self_alive && (n == 4'd2));
	endfunction

endpackage

>>> rtl/life_board_generation_step_core.sv
// Top level of the life board generation step core: board memory, request sequencer,
// generation sweep and result register.
// Depends on lifeb_pkg.
//
// Usage:
//   Requests enter on s_tvalid/s_tready: s_tuser carries the kind (write, read, toggle,
//   step), s_tdata the cell column, row and write value. Each request gives one result
//   on m_tvalid/m_tready: m_tdata carries the cell value, m_tuser the out-of-board flag.
//   Board width and height are written over cfg_valid/cfg_ready; the user must write
//   them only while the core is idle, which the core leaves unenforced. The board sits
//   in a row-wide memory, one row of MAX_WIDTH cells per entry, with a registered read.
//   A cell request reads its row, modifies and writes it back; the result is loaded into
//   the output register as the core returns to idle to take the next request. A step
//   sweeps the rows in place, keeping two old rows in line registers. After reset the
//   core clears all MAX_HEIGHT rows of the memory one row a cycle and holds s_tready low
//   meanwhile; configuration writes are taken throughout. A result waits in the output
//   register while m_tready is low; one further request is taken and processed, then
//   the core holds its result until the output register frees.
module life_board_generation_step_core
	import lifeb_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // col [5:0], row [11:6], alive_in [12], zero [15:13]
	input  logic [1:0]  s_tuser,   // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // alive_out [0], zero [7:1]
	output logic [0:0]  m_tuser    // status [0]
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int GCW = $clog2(MAX_HEIGHT + 2);

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_ACC  = 5'b00100,
		ST_GEN  = 5'b01000,
		ST_RSP  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [GCW-1:0]     cnt_q;
	logic [6:0]         board_width_q;
	logic [6:0]         board_height_q;
	kind_t              req_kind_q;
	logic [CW-1:0]      req_col_q;
	logic [RW-1:0]      req_row_q;
	logic               req_alive_q;
	logic               req_in_board_q;
	logic [MAX_WIDTH-1:0] above_q;
	logic [MAX_WIDTH-1:0] mid_q;
	logic [MAX_WIDTH-1:0] rdata_q;
	logic               res_alive_q;
	logic               res_status_q;
	logic               m_tvalid_q;
	logic               out_alive_q;
	logic               out_status_q;

	logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

	logic [31:0]          w_eff32;
	logic [31:0]          h_eff32;
	logic [5:0]           in_col;
	logic [5:0]           in_row;
	logic [CW+5:0]        in_col_ext;
	logic [RW+5:0]        in_row_ext;
	logic                 in_fire;
	logic                 in_board;
	logic                 out_free;
	logic [MAX_WIDTH-1:0] col_mask;
	logic [MAX_WIDTH-1:0] below_m;
	logic [MAX_WIDTH+1:0] ap;
	logic [MAX_WIDTH+1:0] mp;
	logic [MAX_WIDTH+1:0] bp;
	logic [MAX_WIDTH-1:0] gen_row;
	logic [GCW-1:0]       gen_wrow;
	logic                 gen_last;
	logic [MAX_WIDTH-1:0] acc_row;
	logic [RW-1:0]        mem_raddr;
	logic                 mem_we;
	logic [RW-1:0]        mem_waddr;
	logic [MAX_WIDTH-1:0] mem_wdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {7'd0, out_alive_q};
	assign m_tuser   = out_status_q;

	always_comb begin
		if (board_width_q == 7'd0) begin
			w_eff32 = 32'd1;
		end else if ({25'd0, board_width_q} > 32'(MAX_WIDTH)) begin
			w_eff32 = 32'(MAX_WIDTH);
		end else begin
			w_eff32 = {25'd0, board_width_q};
		end
		if (board_height_q == 7'd0) begin
			h_eff32 = 32'd1;
		end else if ({25'd0, board_height_q} > 32'(MAX_HEIGHT)) begin
			h_eff32 = 32'(MAX_HEIGHT);
		end else begin
			h_eff32 = {25'd0, board_height_q};
		end
	end

	assign in_col     = s_tdata[5:0];
	assign in_row     = s_tdata[11:6];
	assign in_col_ext = {{CW{1'b0}}, in_col};
	assign in_row_ext = {{RW{1'b0}}, in_row};
	assign in_board   = ({26'd0, in_col} < w_eff32) && ({26'd0, in_row} < h_eff32);

	always_comb begin
		for (int j = 0; j < MAX_WIDTH; j++) begin
			col_mask[j] = 32'(j) < w_eff32;
		end
	end

	// Generation datapath: below row arrives from memory, rows above held in line registers.
	assign gen_wrow = cnt_q - GCW'(2);
	assign gen_last = (cnt_q == GCW'(MAX_HEIGHT + 1));

	always_comb begin
		if ((cnt_q != '0) && ((32'(cnt_q) - 32'd1) < h_eff32)) begin
			below_m = rdata_q & col_mask;
		end else begin
			below_m = '0;
		end
		ap = {1'b0, above_q, 1'b0};
		mp = {1'b0, mid_q, 1'b0};
		bp = {1'b0, below_m, 1'b0};
		for (int j = 0; j < MAX_WIDTH; j++) begin
			gen_row[j] = life_rule(mp[j+1],
				{ap[j], ap[j+1], ap[j+2], mp[j], mp[j+2], bp[j], bp[j+1], bp[j+2]})
				&& col_mask[j] && ((32'(cnt_q) - 32'd2) < h_eff32);
		end
	end

	always_comb begin
		acc_row = rdata_q;
		case (req_kind_q)
			KIND_WRITE:  acc_row[req_col_q] = req_alive_q;
			KIND_TOGGLE: acc_row[req_col_q] = ~rdata_q[req_col_q];
			default:     acc_row = rdata_q;
		endcase
	end

	always_comb begin
		mem_raddr = (state_q == ST_GEN) ? cnt_q[RW-1:0] : in_row_ext[RW-1:0];
		mem_we    = 1'b0;
		mem_waddr = cnt_q[RW-1:0];
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_ACC: begin
				mem_waddr = req_row_q;
				mem_wdata = acc_row;
				mem_we    = req_in_board_q &&
					(req_kind_q == KIND_WRITE || req_kind_q == KIND_TOGGLE);
			end
			ST_GEN: begin
				mem_waddr = gen_wrow[RW-1:0];
				mem_wdata = gen_row;
				mem_we    = (cnt_q >= GCW'(2));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_width_q  <= DIM_RESET;
			board_height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IDX_WIDTH:  board_width_q  <= cfg_data;
				CFG_IDX_HEIGHT: board_height_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !(state_q == ST_RSP && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + GCW'(1);
					if (cnt_q == GCW'(MAX_HEIGHT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q   <= '0;
						state_q <= (kind_t'(s_tuser) == KIND_STEP) ? ST_GEN : ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= ST_RSP;
				end
				ST_GEN: begin
					cnt_q <= cnt_q + GCW'(1);
					if (gen_last) begin
						state_q <= ST_RSP;
					end
				end
				ST_RSP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_kind_q     <= kind_t'(s_tuser);
			req_col_q      <= in_col_ext[CW-1:0];
			req_row_q      <= in_row_ext[RW-1:0];
			req_alive_q    <= s_tdata[12];
			req_in_board_q <= in_board;
			above_q        <= '0;
			mid_q          <= '0;
		end else if (state_q == ST_GEN) begin
			above_q <= mid_q;
			mid_q   <= below_m;
		end
		if (state_q == ST_ACC) begin
			res_status_q <= !req_in_board_q && (req_kind_q != KIND_STEP);
			res_alive_q  <= req_in_board_q &&
				(req_kind_q == KIND_READ || req_kind_q == KIND_TOGGLE) && acc_row[req_col_q];
		end else if (state_q == ST_GEN) begin
			res_status_q <= 1'b0;
			res_alive_q  <= 1'b0;
		end
		if (state_q == ST_RSP && out_free) begin
			out_alive_q  <= res_alive_q;
			out_status_q <= res_status_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_ACC || state_q == ST_GEN))
		else $error("request accepted but no access or sweep started");

	a_sweep_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GEN |-> cnt_q <= GCW'(MAX_HEIGHT + 1))
		else $error("generation sweep ran past the last row");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RSP && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented after completion");
`endif

endmodule

>>> tb/tb_life_board_generation_step_core.sv
// Self-checking testbench for life_board_generation_step_core: cell writes, reads, toggles
// and B3/S23 generation steps over several board sizes, with random idling on both streams.
// Depends on lifeb_pkg and the core RTL; predicts every result with its own board model.
`timescale 1ns / 1ps

module tb_life_board_generation_step_core;
	import lifeb_pkg::*;

	localparam int MAX_WIDTH    = 64;
	localparam int MAX_HEIGHT   = 64;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int PHASE_ITEMS  = 150;
	localparam int TAIL_CYCLES  = MAX_HEIGHT + 16;
	localparam int HOLD_CYCLES  = 300;

	class life_board_tracker;
		typedef struct packed {
			logic [7:0] data;
			logic [0:0] status;
		} reply_t;

		bit          cells [MAX_HEIGHT][MAX_WIDTH];
		bit [6:0]    width_raw;
		bit [6:0]    height_raw;
		reply_t      replies [$];
		int unsigned kinds_seen [4];
		int unsigned register_writes;
		int unsigned results_checked;
		int unsigned faults;

		function new();
			width_raw  = DIM_RESET;
			height_raw = DIM_RESET;
		endfunction

		function int unsigned span(bit [6:0] raw, int unsigned limit);
			if (raw == 0)
				return 1;
			if (raw > limit)
				return limit;
			return raw;
		endfunction

		function int unsigned cols_used();
			return span(width_raw, MAX_WIDTH);
		endfunction

		function int unsigned rows_used();
			return span(height_raw, MAX_HEIGHT);
		endfunction

		function int unsigned pending();
			return replies.size();
		endfunction

		function void write_register(logic idx, logic [6:0] value);
			register_writes++;
			if (idx == CFG_IDX_WIDTH)
				width_raw = value;
			else
				height_raw = value;
		endfunction

		function bit cell_at(int c, int r, int w, int h);
			if (c < 0 || r < 0 || c >= w || r >= h)
				return 1'b0;
			return cells[r][c];
		endfunction

		function void advance_generation();
			bit fresh [MAX_HEIGHT][MAX_WIDTH];
			int w;
			int h;
			int n;
			w = cols_used();
			h = rows_used();
			for (int r = 0; r < MAX_HEIGHT; r++) begin
				for (int c = 0; c < MAX_WIDTH; c++) begin
					if (r >= h || c >= w) begin
						fresh[r][c] = 1'b0;
					end else begin
						n = 0;
						for (int dr = -1; dr <= 1; dr++)
							for (int dc = -1; dc <= 1; dc++)
								if (dr != 0 || dc != 0)
									n += cell_at(c + dc, r + dr, w, h);
						fresh[r][c] = (n == 3) || (cells[r][c] && n == 2);
					end
				end
			end
			cells = fresh;
		endfunction

		function void apply_request(kind_t kind, bit [5:0] col, bit [5:0] row, bit alive);
			reply_t want;
			want = '0;
			kinds_seen[kind]++;
			if (kind == KIND_STEP) begin
				advance_generation();
			end else if (col >= cols_used() || row >= rows_used()) begin
				want.status = 1'b1;
			end else begin
				case (kind)
					KIND_WRITE: cells[row][col] = alive;
					KIND_READ: want.data[0] = cells[row][col];
					default: begin
						cells[row][col] = !cells[row][col];
						want.data[0] = cells[row][col];
					end
				endcase
			end
			replies.push_back(want);
		endfunction

		function void check_result(logic [7:0] data, logic [0:0] status);
			reply_t want;
			results_checked++;
			if (replies.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result data=%h status=%b with no request pending",
						$realtime, data, status);
				return;
			end
			want = replies.pop_front();
			if (data !== want.data || status !== want.status) begin
				faults++;
				if (faults <= 10)
					$display("%0t: result mismatch: expected data=%h status=%b, got data=%h status=%b",
						$realtime, want.data, want.status, data, status);
			end
		endfunction
	endclass

	bit          clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [6:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // col [5:0], row [11:6], alive_in [12], zero [15:13]
	logic [1:0]  s_tuser = '0;    // kind [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // alive_out [0], zero [7:1]
	logic [0:0]  m_tuser;         // status [0]

	life_board_tracker tracker;
	int unsigned       cycle_count;
	int unsigned       sent;
	int unsigned       hold_off;
	int unsigned       rx_stall;
	bit                rx_calm;
	bit                tx_calm;
	bit [6:0]          phase_w [10];
	bit [6:0]          phase_h [10];

	life_board_generation_step_core #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("life_board_generation_step_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tracker.write_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				tracker.apply_request(kind_t'(s_tuser), s_tdata[5:0], s_tdata[11:6], s_tdata[12]);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata, m_tuser);
		end
	end

	function automatic int unsigned idle_span();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned sender_gap();
		if (tx_calm || $urandom_range(0, 99) < 60)
			return 0;
		return idle_span();
	endfunction

	function automatic bit [5:0] near_coord(int unsigned c);
		int v;
		v = int'(c) + int'($urandom_range(0, 4)) - 2;
		return v[5:0];
	endfunction

	always @(posedge clk) begin
		if (hold_off != 0) begin
			m_tready <= 1'b0;
			hold_off--;
		end else if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if (!rx_calm && $urandom_range(0, 3) == 0)
				rx_stall = idle_span();
		end
		if ($urandom_range(0, 299) == 0)
			rx_calm = !rx_calm;
	end

	task automatic send_request(kind_t kind, bit [5:0] col, bit [5:0] row, bit alive);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, alive, row, col};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic write_register(logic idx, bit [6:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_board(bit [6:0] w, bit [6:0] h);
		wait_idle();
		write_register(CFG_IDX_WIDTH, w);
		write_register(CFG_IDX_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_pattern();
		int unsigned cx;
		int unsigned cy;
		cx = $urandom_range(0, tracker.cols_used() - 1);
		cy = $urandom_range(0, tracker.rows_used() - 1);
		repeat ($urandom_range(3, 12))
			send_request(($urandom_range(0, 4) == 0) ? KIND_TOGGLE : KIND_WRITE,
				near_coord(cx), near_coord(cy), $urandom_range(0, 3) != 0);
		repeat ($urandom_range(1, 3))
			send_request(KIND_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				1'($urandom_range(0, 1)));
		repeat ($urandom_range(4, 10))
			send_request(KIND_READ, near_coord(cx), near_coord(cy), 1'($urandom_range(0, 1)));
	endtask

	task automatic run_noise();
		kind_t kind;
		repeat ($urandom_range(2, 8)) begin
			kind = ($urandom_range(0, 7) == 0) ? KIND_STEP : kind_t'($urandom_range(0, 2));
			send_request(kind, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int unsigned goal;

		phase_w = '{64, 0, 1, 3, 127, 1, 64, 65, 8, 16};
		phase_h = '{64, 0, 1, 3, 127, 64, 1, 2, 8, 12};
		tracker = new();
		tx_calm = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners, blinker and block on the full board
		send_request(KIND_WRITE, 0, 0, 1'b1);
		send_request(KIND_WRITE, 63, 63, 1'b1);
		send_request(KIND_READ, 63, 63, 1'b0);
		send_request(KIND_TOGGLE, 63, 0, 1'b0);
		send_request(KIND_TOGGLE, 63, 0, 1'b1);
		send_request(KIND_WRITE, 7, 10, 1'b1);
		send_request(KIND_WRITE, 8, 10, 1'b1);
		send_request(KIND_WRITE, 9, 10, 1'b1);
		send_request(KIND_WRITE, 21, 20, 1'b1);
		send_request(KIND_WRITE, 20, 20, 1'b1);
		send_request(KIND_WRITE, 20, 21, 1'b1);
		send_request(KIND_WRITE, 21, 21, 1'b1);
		send_request(KIND_STEP, 0, 0, 1'b0);
		send_request(KIND_READ, 8, 9, 1'b0);
		send_request(KIND_READ, 63, 63, 1'b0);

		// shrink: out-of-board accesses, then a step that clears the rest
		set_board(30, 4);
		send_request(KIND_READ, 30, 0, 1'b0);
		send_request(KIND_WRITE, 0, 4, 1'b1);
		send_request(KIND_TOGGLE, 63, 63, 1'b1);
		send_request(KIND_STEP, 63, 63, 1'b1);
		set_board(64, 64);
		send_request(KIND_READ, 20, 20, 1'b0);
		send_request(KIND_READ, 8, 9, 1'b0);

		for (int p = 0; p < 12; p++) begin
			if (p < 10)
				set_board(phase_w[p], phase_h[p]);
			else
				set_board(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
			tx_calm = ($urandom_range(0, 3) == 0);
			if (p == 0) begin
				// hold the result stream while requests keep coming, then let it drain
				hold_off = HOLD_CYCLES;
				tx_calm = 1'b1;
				run_pattern();
				run_pattern();
				wait_idle();
				tx_calm = 1'b0;
			end
			goal = sent + PHASE_ITEMS;
			while (sent < goal) begin
				if ($urandom_range(0, 9) < 7)
					run_pattern();
				else
					run_noise();
				if ($urandom_range(0, 24) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d writes, %0d reads, %0d toggles, %0d steps.",
			sent, tracker.kinds_seen[KIND_WRITE], tracker.kinds_seen[KIND_READ],
			tracker.kinds_seen[KIND_TOGGLE], tracker.kinds_seen[KIND_STEP]);
		$display("Checked %0d results over %0d register writes; %0d mismatches, %0d left open.",
			tracker.results_checked, tracker.register_writes, tracker.faults,
			tracker.pending());
		if (tracker.faults == 0 && tracker.pending() == 0)
			$display("life_board_generation_step_core regression: pass");
		else
			$display("life_board_generation_step_core regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lifeb_pkg.sv
rtl/life_board_generation_step_core.sv
tb/tb_life_board_generation_step_core.sv
